@@ sv/tcprx_pkg.sv @@
// Shared types, codes and constants of the TCP receive state machine.
package tcprx_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 216;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [15:0] RCV_WINDOW_RST = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLOSED      = 4'd0,
        ST_LISTEN      = 4'd1,
        ST_SYN_SENT    = 4'd2,
        ST_SYN_RECV    = 4'd3,
        ST_ESTABLISHED = 4'd4,
        ST_FIN_WAIT1   = 4'd5,
        ST_CLOSING     = 4'd6,
        ST_TIME_WAIT   = 4'd7,
        ST_CLOSE_WAIT  = 4'd8,
        ST_LAST_ACK    = 4'd9
    } conn_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OPEN_MODE      = 2'd0,
        CFG_INITIAL_SEQ    = 2'd1,
        CFG_RECEIVE_WINDOW = 2'd2
    } cfg_reg_t;

    localparam logic [1:0] MODE_LISTEN   = 2'd1;
    localparam logic [1:0] MODE_SYN_SENT = 2'd2;

    typedef struct packed {
        logic        drop;
        logic        fin;
        logic        syn;
        logic        rst;
        logic        psh;
        logic        ack;
        logic        has_data;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] payload_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } seg_cmd_t;

    typedef struct packed {
        conn_state_t conn_state;
        logic [31:0] rcv_next;
        logic [31:0] snd_next;
        logic [15:0] rcv_window;
        logic [31:0] ack_due_count;
        logic        data_accepted;
        logic        data_ready;
        logic        dropped;
        logic [31:0] local_addr;
        logic [15:0] local_port;
        logic [31:0] peer_addr;
        logic [15:0] peer_port;
    } seg_result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic conn_state_t mode_to_state(input logic [1:0] mode);
        conn_state_t st;
        case (mode)
            MODE_LISTEN:   st = ST_LISTEN;
            MODE_SYN_SENT: st = ST_SYN_SENT;
            default:       st = ST_CLOSED;
        endcase
        return st;
    endfunction

endpackage

@@ sv/tcp_receive_state_machine_top.sv @@
// Top level of the TCP receive state machine for one connection.
//
// The slave stream carries one parsed segment header per transaction: the
// checksum verdict in tuser and the flags, sequence numbers, payload length,
// addresses and ports in tdata. The master stream returns one result per
// segment with the connection state and counters after the update, and the
// bad-checksum drop flag in tuser.
// The configuration channel writes open mode, initial send sequence and
// receive window; each write loads the matching connection register. It is
// always ready and is meant to be used only while no segment is in flight.
// An accepted segment passes through the command queue and the result register
// to the master side. One segment is taken per cycle while the queue is not
// full; the update engine pops one when the result register is free or read.
// A four-entry command queue sits between the decoder and the update engine,
// so the slave side keeps accepting while the master side stalls until the
// queue and the result register are full.
// After reset the connection is closed, the window is 65535 and all
// sequence numbers, counters and recorded endpoints are zero.
module tcp_receive_state_machine_top #(
    parameter int QUEUE_DEPTH = tcprx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tcp_flags, seq_num, ack_num, payload_len, src_addr, dst_addr,
    // src_port, dst_port, zero padding
    input  logic [tcprx_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // checksum_ok
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // conn_state, rcv_next, snd_next, rcv_window, ack_due_count,
    // data_accepted, data_ready, local_addr, local_port, peer_addr,
    // peer_port, zero padding
    output logic [tcprx_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // dropped
    output logic                                   m_axis_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tcprx_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tcprx_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import tcprx_pkg::*;

    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;
    seg_cmd_t      push_cmd;
    seg_cmd_t      pop_cmd;
    seg_result_t   res;
    cfg_reg_t      cfg_sel;

    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_reg_t'(cfg_index);

    tcprx_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    tcprx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    tcprx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_sel   (cfg_sel),
        .cfg_wdata (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {2'b00, res.peer_port, res.peer_addr, res.local_port,
                           res.local_addr, res.data_ready, res.data_accepted,
                           res.ack_due_count, res.rcv_window, res.snd_next,
                           res.rcv_next, res.conn_state};
    assign m_axis_tuser = res.dropped;

    a_drop_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.dropped |-> !res.data_accepted && !res.data_ready)
        else $error("dropped segment reports accepted data");

    a_ready_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.data_ready |-> res.data_accepted)
        else $error("PSH readiness without accepted data");

    a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.data_accepted |->
            (res.conn_state == ST_ESTABLISHED || res.conn_state == ST_LAST_ACK))
        else $error("data accepted outside an open connection");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !s_axis_tready && !q_push)
        else $error("segment taken while the queue is full");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue popped while empty");

endmodule

@@ sv/tcprx_front.sv @@
// Front end: accepts segment headers and decodes them into commands for the queue.
module tcprx_front (
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tcprx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  tcprx_pkg::queue_status_t            q_status,
    output logic                                q_push,
    output tcprx_pkg::seg_cmd_t                 q_cmd
);
    import tcprx_pkg::*;

    logic [4:0] flags;

    assign flags         = s_axis_tdata[4:0];
    assign s_axis_tready = !q_status.full;
    assign q_push        = s_axis_tvalid && !q_status.full;

    always_comb
    begin
        q_cmd.drop        = !s_axis_tuser;
        q_cmd.fin         = flags[0];
        q_cmd.syn         = flags[1];
        q_cmd.rst         = flags[2];
        q_cmd.psh         = flags[3];
        q_cmd.ack         = flags[4];
        q_cmd.seq_num     = s_axis_tdata[36:5];
        q_cmd.ack_num     = s_axis_tdata[68:37];
        q_cmd.payload_len = s_axis_tdata[84:69];
        q_cmd.has_data    = (s_axis_tdata[84:69] != 16'd0);
        q_cmd.src_addr    = s_axis_tdata[116:85];
        q_cmd.dst_addr    = s_axis_tdata[148:117];
        q_cmd.src_port    = s_axis_tdata[164:149];
        q_cmd.dst_port    = s_axis_tdata[180:165];
    end

endmodule

@@ sv/tcprx_queue.sv @@
// Short command queue between the front end and the state update engine.
module tcprx_queue #(
    parameter int DEPTH = tcprx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  tcprx_pkg::seg_cmd_t        push_cmd,
    input  logic                       pop,
    output tcprx_pkg::seg_cmd_t        pop_cmd,
    output tcprx_pkg::queue_status_t   status
);
    import tcprx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    seg_cmd_t         entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_cmd      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/tcprx_back.sv @@
// Back end: connection state update, configuration loads and the result register.
module tcprx_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcprx_pkg::queue_status_t            q_status,
    input  tcprx_pkg::seg_cmd_t                 q_cmd,
    output logic                                q_pop,
    input  logic                                cfg_we,
    input  tcprx_pkg::cfg_reg_t                 cfg_sel,
    input  logic [tcprx_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic                                res_valid,
    input  logic                                res_ready,
    output tcprx_pkg::seg_result_t              res
);
    import tcprx_pkg::*;

    conn_state_t state_reg, state_next;
    logic [31:0] rcv_next_reg, rcv_next_next;
    logic [31:0] snd_next_reg, snd_next_next;
    logic [15:0] window_reg, window_next;
    logic [31:0] ack_count_reg, ack_count_next;
    logic [31:0] local_addr_reg, local_addr_next;
    logic [15:0] local_port_reg, local_port_next;
    logic [31:0] peer_addr_reg, peer_addr_next;
    logic [15:0] peer_port_reg, peer_port_next;
    logic        out_valid_reg, out_valid_next;
    seg_result_t out_res_reg, out_res_next;

    logic        in_order;
    logic        accepted;
    logic        ready;
    logic [31:0] rcv_after_data;

    assign q_pop     = !q_status.empty && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

    assign in_order       = q_cmd.has_data && (q_cmd.seq_num == rcv_next_reg);
    assign accepted       = in_order;
    assign ready          = in_order && q_cmd.psh;
    assign rcv_after_data = in_order ? rcv_next_reg + {16'd0, q_cmd.payload_len}
                                     : rcv_next_reg;

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we && cfg_sel == CFG_OPEN_MODE)
        begin
            state_next = mode_to_state(cfg_wdata[1:0]);
        end
        else if (q_pop && !q_cmd.drop)
        begin
            case (state_reg)
                ST_LISTEN:
                begin
                    if (q_cmd.syn)
                    begin
                        state_next = ST_SYN_RECV;
                    end
                end
                ST_SYN_SENT:
                begin
                    if (q_cmd.syn && q_cmd.ack)
                    begin
                        state_next = ST_ESTABLISHED;
                    end
                    else if (q_cmd.rst)
                    begin
                        state_next = ST_CLOSED;
                    end
                end
                ST_SYN_RECV:
                begin
                    if (q_cmd.ack)
                    begin
                        state_next = ST_ESTABLISHED;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (q_cmd.fin)
                    begin
                        state_next = ST_LAST_ACK;
                    end
                end
                ST_FIN_WAIT1:
                begin
                    if (q_cmd.fin)
                    begin
                        state_next = q_cmd.ack ? ST_TIME_WAIT : ST_CLOSING;
                    end
                end
                ST_CLOSING:
                begin
                    if (q_cmd.fin && q_cmd.ack)
                    begin
                        state_next = ST_TIME_WAIT;
                    end
                end
                ST_LAST_ACK:
                begin
                    if (q_cmd.ack)
                    begin
                        state_next = ST_CLOSED;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        rcv_next_next   = rcv_next_reg;
        snd_next_next   = snd_next_reg;
        window_next     = window_reg;
        ack_count_next  = ack_count_reg;
        local_addr_next = local_addr_reg;
        local_port_next = local_port_reg;
        peer_addr_next  = peer_addr_reg;
        peer_port_next  = peer_port_reg;
        if (cfg_we)
        begin
            case (cfg_sel)
                CFG_INITIAL_SEQ:    snd_next_next = cfg_wdata;
                CFG_RECEIVE_WINDOW: window_next   = cfg_wdata[15:0];
                default:            snd_next_next = snd_next_reg;
            endcase
        end
        else if (q_pop && !q_cmd.drop)
        begin
            case (state_reg)
                ST_LISTEN:
                begin
                    local_addr_next = q_cmd.dst_addr;
                    local_port_next = q_cmd.dst_port;
                    peer_addr_next  = q_cmd.src_addr;
                    peer_port_next  = q_cmd.src_port;
                    if (q_cmd.syn)
                    begin
                        rcv_next_next = q_cmd.seq_num + 32'd1;
                    end
                end
                ST_SYN_SENT:
                begin
                    if (q_cmd.syn && q_cmd.ack)
                    begin
                        rcv_next_next  = q_cmd.seq_num + 32'd1;
                        snd_next_next  = snd_next_reg + 32'd1;
                        ack_count_next = '0;
                    end
                end
                ST_SYN_RECV:
                begin
                    if (q_cmd.ack)
                    begin
                        snd_next_next = q_cmd.ack_num;
                    end
                end
                ST_ESTABLISHED:
                begin
                    rcv_next_next = rcv_after_data;
                    if (in_order)
                    begin
                        window_next = (window_reg > q_cmd.payload_len)
                                    ? window_reg - q_cmd.payload_len : '0;
                        if (q_cmd.psh)
                        begin
                            ack_count_next = '0;
                        end
                    end
                    else if (q_cmd.has_data)
                    begin
                        ack_count_next = ack_count_reg - 32'd1;
                    end
                    if (q_cmd.fin)
                    begin
                        rcv_next_next = rcv_after_data + 32'd1;
                    end
                    else if (!q_cmd.rst && q_cmd.syn && q_cmd.ack)
                    begin
                        ack_count_next = '0;
                    end
                end
                ST_FIN_WAIT1:
                begin
                    if (q_cmd.fin && q_cmd.ack)
                    begin
                        rcv_next_next = rcv_next_reg + 32'd1;
                        snd_next_next = snd_next_reg + 32'd1;
                    end
                end
                ST_TIME_WAIT:
                begin
                    if (q_cmd.fin && q_cmd.ack)
                    begin
                        ack_count_next = '0;
                    end
                end
                default:
                begin
                    rcv_next_next = rcv_next_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (q_pop)
        begin
            out_valid_next              = 1'b1;
            out_res_next.conn_state     = state_next;
            out_res_next.rcv_next       = rcv_next_next;
            out_res_next.snd_next       = snd_next_next;
            out_res_next.rcv_window     = window_next;
            out_res_next.ack_due_count  = ack_count_next;
            out_res_next.data_accepted  = !q_cmd.drop && state_reg == ST_ESTABLISHED
                                          && accepted;
            out_res_next.data_ready     = !q_cmd.drop && state_reg == ST_ESTABLISHED
                                          && ready;
            out_res_next.dropped        = q_cmd.drop;
            out_res_next.local_addr     = local_addr_next;
            out_res_next.local_port     = local_port_next;
            out_res_next.peer_addr      = peer_addr_next;
            out_res_next.peer_port      = peer_port_next;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLOSED;
            rcv_next_reg   <= '0;
            snd_next_reg   <= '0;
            window_reg     <= RCV_WINDOW_RST;
            ack_count_reg  <= '0;
            local_addr_reg <= '0;
            local_port_reg <= '0;
            peer_addr_reg  <= '0;
            peer_port_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rcv_next_reg   <= rcv_next_next;
            snd_next_reg   <= snd_next_next;
            window_reg     <= window_next;
            ack_count_reg  <= ack_count_next;
            local_addr_reg <= local_addr_next;
            local_port_reg <= local_port_next;
            peer_addr_reg  <= peer_addr_next;
            peer_port_reg  <= peer_port_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

@@ bench/tcp_receive_state_machine_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the TCP receive state machine with a connection predictor.
module tcp_receive_state_machine_top_tb;
    import tcprx_pkg::*;

    localparam bit [4:0] FLAG_FIN = 5'h01;
    localparam bit [4:0] FLAG_SYN = 5'h02;
    localparam bit [4:0] FLAG_RST = 5'h04;
    localparam bit [4:0] FLAG_PSH = 5'h08;
    localparam bit [4:0] FLAG_ACK = 5'h10;

    localparam logic [1:0] MODE_CLOSED  = 2'd0;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    localparam int RESET_CYCLES    = 10;
    localparam int RANDOM_SEGMENTS = 800;
    localparam int DRAIN_CYCLES    = 8;
    localparam int SHOW_LIMIT      = 10;

    typedef struct {
        bit        checksum_ok;
        bit [4:0]  flags;
        bit [31:0] seq_num;
        bit [31:0] ack_num;
        bit [15:0] payload_len;
        bit [31:0] src_addr;
        bit [31:0] dst_addr;
        bit [15:0] src_port;
        bit [15:0] dst_port;
    } segment_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    conn_state_t conn_st;
    logic [1:0]  open_mode_cfg;
    logic [31:0] rcv_nxt;
    logic [31:0] snd_nxt;
    logic [15:0] wnd;
    logic [31:0] ack_due;
    logic [31:0] local_addr_q;
    logic [15:0] local_port_q;
    logic [31:0] peer_addr_q;
    logic [15:0] peer_port_q;

    seg_result_t expected_results[$];
    seg_result_t oldest_expected;
    int          mismatch_count = 0;
    int          counted_segments = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;

    tcp_receive_state_machine_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void reset_predictor();
        open_mode_cfg   = MODE_CLOSED;
        conn_st         = ST_CLOSED;
        rcv_nxt         = '0;
        snd_nxt         = '0;
        wnd             = RCV_WINDOW_RST;
        ack_due         = '0;
        local_addr_q    = '0;
        local_port_q    = '0;
        peer_addr_q     = '0;
        peer_port_q     = '0;
    endfunction

    function automatic seg_result_t advance_connection(input segment_t sg);
        seg_result_t r;
        bit          fin;
        bit          syn;
        bit          rst;
        bit          psh;
        bit          ack;
        r   = '0;
        fin = |(sg.flags & FLAG_FIN);
        syn = |(sg.flags & FLAG_SYN);
        rst = |(sg.flags & FLAG_RST);
        psh = |(sg.flags & FLAG_PSH);
        ack = |(sg.flags & FLAG_ACK);
        if (!sg.checksum_ok)
        begin
            r.dropped = 1'b1;
        end
        else
        begin
            case (conn_st)
                ST_LISTEN:
                begin
                    local_addr_q = sg.dst_addr;
                    local_port_q = sg.dst_port;
                    peer_addr_q  = sg.src_addr;
                    peer_port_q  = sg.src_port;
                    if (syn)
                    begin
                        conn_st = ST_SYN_RECV;
                        rcv_nxt = sg.seq_num + 32'd1;
                    end
                end
                ST_SYN_SENT:
                begin
                    if (syn && ack)
                    begin
                        conn_st = ST_ESTABLISHED;
                        rcv_nxt = sg.seq_num + 32'd1;
                        snd_nxt = snd_nxt + 32'd1;
                        ack_due = '0;
                    end
                    else if (rst)
                    begin
                        conn_st = ST_CLOSED;
                    end
                end
                ST_SYN_RECV:
                begin
                    if (ack)
                    begin
                        snd_nxt = sg.ack_num;
                        conn_st = ST_ESTABLISHED;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (sg.payload_len != 16'd0)
                    begin
                        if (sg.seq_num == rcv_nxt)
                        begin
                            rcv_nxt = rcv_nxt + {16'd0, sg.payload_len};
                            wnd = (wnd > sg.payload_len) ? wnd - sg.payload_len : 16'd0;
                            if (psh)
                            begin
                                r.data_ready = 1'b1;
                                ack_due = '0;
                            end
                            r.data_accepted = 1'b1;
                        end
                        else
                        begin
                            ack_due = ack_due - 32'd1;
                        end
                    end
                    if (fin)
                    begin
                        conn_st = ST_LAST_ACK;
                        rcv_nxt = rcv_nxt + 32'd1;
                    end
                    else if (!rst && syn && ack)
                    begin
                        ack_due = '0;
                    end
                end
                ST_FIN_WAIT1:
                begin
                    if (fin && ack)
                    begin
                        conn_st = ST_TIME_WAIT;
                        rcv_nxt = rcv_nxt + 32'd1;
                        snd_nxt = snd_nxt + 32'd1;
                    end
                    else if (fin)
                    begin
                        conn_st = ST_CLOSING;
                    end
                end
                ST_CLOSING:
                begin
                    if (fin && ack)
                        conn_st = ST_TIME_WAIT;
                end
                ST_TIME_WAIT:
                begin
                    if (fin && ack)
                        ack_due = '0;
                end
                ST_LAST_ACK:
                begin
                    if (ack)
                        conn_st = ST_CLOSED;
                end
                default:
                begin
                end
            endcase
        end
        r.conn_state    = conn_st;
        r.rcv_next      = rcv_nxt;
        r.snd_next      = snd_nxt;
        r.rcv_window    = wnd;
        r.ack_due_count = ack_due;
        r.local_addr    = local_addr_q;
        r.local_port    = local_port_q;
        r.peer_addr     = peer_addr_q;
        r.peer_port     = peer_port_q;
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_segment(input segment_t sg);
        logic [IN_TDATA_W-1:0] v;
        v = {3'b000, sg.dst_port, sg.src_port, sg.dst_addr, sg.src_addr,
             sg.payload_len, sg.ack_num, sg.seq_num, sg.flags};
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT)
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("%0t: result transaction with nothing expected, got %h",
                             $time, m_axis_tdata);
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                check_field("conn_state", 32'(oldest_expected.conn_state),
                            32'(m_axis_tdata[3:0]));
                check_field("rcv_next", oldest_expected.rcv_next, m_axis_tdata[35:4]);
                check_field("snd_next", oldest_expected.snd_next, m_axis_tdata[67:36]);
                check_field("rcv_window", 32'(oldest_expected.rcv_window),
                            32'(m_axis_tdata[83:68]));
                check_field("ack_due_count", oldest_expected.ack_due_count,
                            m_axis_tdata[115:84]);
                check_field("data_accepted", 32'(oldest_expected.data_accepted),
                            32'(m_axis_tdata[116]));
                check_field("data_ready", 32'(oldest_expected.data_ready),
                            32'(m_axis_tdata[117]));
                check_field("local_addr", oldest_expected.local_addr, m_axis_tdata[149:118]);
                check_field("local_port", 32'(oldest_expected.local_port),
                            32'(m_axis_tdata[165:150]));
                check_field("peer_addr", oldest_expected.peer_addr, m_axis_tdata[197:166]);
                check_field("peer_port", 32'(oldest_expected.peer_port),
                            32'(m_axis_tdata[213:198]));
                check_field("dropped", 32'(oldest_expected.dropped), 32'(m_axis_tuser));
            end
        end
    end

    task automatic send_segment(input segment_t sg);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= sg.checksum_ok;
        s_axis_tdata  <= pack_segment(sg);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(advance_connection(sg));
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_OPEN_MODE:
            begin
                open_mode_cfg = value[1:0];
                if (open_mode_cfg == MODE_LISTEN)
                    conn_st = ST_LISTEN;
                else if (open_mode_cfg == MODE_SYN_SENT)
                    conn_st = ST_SYN_SENT;
                else
                    conn_st = ST_CLOSED;
            end
            CFG_INITIAL_SEQ:
            begin
                snd_nxt = value;
            end
            CFG_RECEIVE_WINDOW:
            begin
                wnd = value[15:0];
            end
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic open_connection(input logic [1:0] mode, input logic [31:0] isn,
                                   input logic [15:0] window);
        settle();
        write_register(CFG_RECEIVE_WINDOW, {16'd0, window});
        write_register(CFG_INITIAL_SEQ, isn);
        write_register(CFG_OPEN_MODE, {30'd0, mode});
    endtask

    function automatic segment_t make_segment(input bit ok, input bit [4:0] flags,
                                              input bit [31:0] seq, input bit [15:0] len);
        segment_t sg;
        sg.checksum_ok = ok;
        sg.flags       = flags;
        sg.seq_num     = seq;
        sg.ack_num     = $urandom;
        sg.payload_len = len;
        sg.src_addr    = $urandom;
        sg.dst_addr    = $urandom;
        sg.src_port    = 16'($urandom);
        sg.dst_port    = 16'($urandom);
        return sg;
    endfunction

    function automatic segment_t uniform_segment(input bit v);
        segment_t sg;
        sg.checksum_ok = v;
        sg.flags       = {5{v}};
        sg.seq_num     = {32{v}};
        sg.ack_num     = {32{v}};
        sg.payload_len = {16{v}};
        sg.src_addr    = {32{v}};
        sg.dst_addr    = {32{v}};
        sg.src_port    = {16{v}};
        sg.dst_port    = {16{v}};
        return sg;
    endfunction

    function automatic bit [15:0] random_length();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return 16'd0;
        else if (pick == 1)
            return 16'hFFFF;
        else if (pick == 2)
            return 16'($urandom);
        return 16'($urandom_range(1, 1500));
    endfunction

    function automatic segment_t next_random_segment();
        segment_t sg;
        int       pick;
        sg = make_segment(1'b1, 5'($urandom), $urandom, random_length());
        if ($urandom_range(99) < 12)
        begin
            sg.checksum_ok = 1'($urandom_range(1));
            return sg;
        end
        sg.checksum_ok = ($urandom_range(19) != 0);
        pick = $urandom_range(99);
        case (conn_st)
            ST_LISTEN:
            begin
                if (pick < 60)
                    sg.flags = FLAG_SYN;
            end
            ST_SYN_SENT:
            begin
                if (pick < 70)
                    sg.flags = FLAG_SYN | FLAG_ACK;
                else if (pick < 85)
                    sg.flags = FLAG_RST;
            end
            ST_SYN_RECV:
            begin
                if (pick < 80)
                    sg.flags = FLAG_ACK | ($urandom_range(1) ? FLAG_PSH : 5'd0);
            end
            ST_ESTABLISHED:
            begin
                if (pick < 75)
                    sg.seq_num = rcv_nxt;
                else if (pick < 88)
                    sg.seq_num = rcv_nxt + $urandom_range(1, 3000);
                sg.flags = FLAG_ACK | ($urandom_range(1) ? FLAG_PSH : 5'd0);
                case ($urandom_range(29))
                    0: sg.flags = sg.flags | FLAG_FIN;
                    1: sg.flags = sg.flags | FLAG_SYN;
                    2: sg.flags = sg.flags | FLAG_RST;
                    3: sg.flags = 5'($urandom);
                    default: sg.flags = sg.flags;
                endcase
            end
            ST_LAST_ACK:
            begin
                if (pick < 70)
                    sg.flags = FLAG_ACK | ($urandom_range(1) ? FLAG_FIN : 5'd0);
                else
                    sg.flags = sg.flags & ~FLAG_ACK;
            end
            default:
            begin
            end
        endcase
        return sg;
    endfunction

    task automatic test_closed_after_reset();
        send_segment(uniform_segment(1'b1));
        send_segment(uniform_segment(1'b0));
        send_segment(make_segment(1'b1, FLAG_SYN, $urandom, 16'd10));
    endtask

    task automatic test_passive_open();
        open_connection(MODE_LISTEN, 32'hFFFF_FFFF, 16'd100);
        send_segment(make_segment(1'b1, FLAG_ACK, $urandom, 16'd0));
        send_segment(make_segment(1'b0, FLAG_SYN, $urandom, 16'd0));
        // An all-ones SYN wraps the receive sequence number to zero.
        send_segment(uniform_segment(1'b1));
        send_segment(make_segment(1'b1, FLAG_PSH, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_ACK, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_ACK | FLAG_PSH, rcv_nxt, 16'd40));
        send_segment(make_segment(1'b1, FLAG_ACK, rcv_nxt + 32'd5, 16'd10));
        send_segment(make_segment(1'b1, FLAG_ACK, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_SYN | FLAG_ACK, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_ACK, rcv_nxt, 16'hFFFF));
        send_segment(make_segment(1'b1, FLAG_RST, rcv_nxt + 32'd1, 16'd3));
        send_segment(make_segment(1'b1, FLAG_FIN | FLAG_ACK, rcv_nxt, 16'd1));
        send_segment(make_segment(1'b1, FLAG_FIN, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_ACK, $urandom, 16'd0));
    endtask

    task automatic test_active_open();
        open_connection(MODE_SYN_SENT, 32'hFFFF_FFFF, 16'd0);
        send_segment(make_segment(1'b1, FLAG_ACK, $urandom, 16'd0));
        send_segment(make_segment(1'b1, FLAG_RST, $urandom, 16'd0));
        settle();
        write_register(CFG_OPEN_MODE, {30'd0, MODE_SYN_SENT});
        send_segment(make_segment(1'b1, FLAG_SYN | FLAG_ACK, 32'hFFFF_FFFF, 16'd0));
        send_segment(make_segment(1'b1, FLAG_ACK | FLAG_PSH, rcv_nxt, 16'd1));
    endtask

    task automatic test_unused_open_mode();
        settle();
        write_register(CFG_OPEN_MODE, {30'd0, MODE_UNUSED});
        send_segment(make_segment(1'b1, FLAG_SYN, $urandom, 16'd0));
    endtask

    task automatic random_connection();
        logic [1:0]  mode;
        logic [31:0] isn;
        logic [15:0] window;
        int          pick;
        int          remaining;
        pick = $urandom_range(19);
        mode = (pick < 9) ? MODE_LISTEN : (pick < 18) ? MODE_SYN_SENT :
               (pick == 18) ? MODE_CLOSED : MODE_UNUSED;
        case ($urandom_range(5))
            0: isn = '0;
            1: isn = 32'hFFFF_FFFF;
            default: isn = $urandom;
        endcase
        case ($urandom_range(5))
            0: window = '0;
            1: window = 16'hFFFF;
            2: window = 16'($urandom);
            default: window = 16'($urandom_range(1, 8000));
        endcase
        open_connection(mode, isn, window);
        remaining = $urandom_range(10, 40);
        while (remaining > 0)
        begin
            if (conn_st == ST_CLOSED)
            begin
                send_segment(next_random_segment());
                remaining = 0;
            end
            else
            begin
                send_segment(next_random_segment());
                counted_segments++;
                remaining--;
            end
        end
    endtask

    task automatic test_random_connections();
        while (counted_segments < RANDOM_SEGMENTS)
        begin
            case (counted_segments * 4 / RANDOM_SEGMENTS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 49;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 49;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            random_connection();
        end
    endtask

    initial
    begin
        reset_predictor();
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_closed_after_reset();
        test_passive_open();
        test_active_open();
        test_unused_open_mode();
        test_random_connections();
        settle();
        if (mismatch_count == 0)
            $display("tcp_receive_state_machine_top_tb OK");
        else
            $display("tcp_receive_state_machine_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tcp_receive_state_machine_top_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tcprx_pkg.sv
sv/tcprx_front.sv
sv/tcprx_queue.sv
sv/tcprx_back.sv
sv/tcp_receive_state_machine_top.sv
bench/tcp_receive_state_machine_top_tb.sv
